/* rtl/udt_pkg.sv */
// UDP endpoint demux table: shared types, sizes and helpers.
// Used by every module of the block but udt_queue_ram; depends on nothing.
package udt_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int HANDLE_BITS = 16;

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QWORDS  = SLOT_COUNT * QUEUE_DEPTH;
    localparam int QADDR_W = (QWORDS > 1) ? $clog2(QWORDS) : 1;

    typedef enum logic [1:0] {
        MODE_FREE = 2'd0,
        MODE_USED = 2'd1,
        MODE_WAIT = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        FN_REGISTER = 3'd0,
        FN_RELEASE  = 3'd1,
        FN_DELIVER  = 3'd2,
        FN_RECV     = 3'd3,
        FN_RECV_LP  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOMATCH = 3'd3,
        ST_WAITING = 3'd4,
        ST_DROPPED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_READ,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic [15:0] local_port;
        logic [15:0] buffer_handle;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot;
        logic [15:0] handle_out;
        logic        handle_valid;
        logic        wake;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] rport;
        logic [15:0] lport;
    } tag_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } match_t;

    function automatic logic [HEAD_W-1:0] ptr_inc(input logic [HEAD_W-1:0] p);
        return (p == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [QADDR_W-1:0] q_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [HEAD_W-1:0] p);
        return QADDR_W'(s) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(p);
    endfunction

endpackage

/* rtl/udp_endpoint_demux_table_core.sv */
// UDP endpoint demux table, top level.
// Depends on udt_pkg and udt_core_ctrl.
//
//  channel | ports              | direction | payload
//  --------+--------------------+-----------+------------------
//  input   | s_valid/s_ready    | in        | s_data  (in_t)
//  result  | m_valid/m_ready    | out       | m_data  (out_t)
//
// One transaction at a time: accept, a lookup state, then the result
// register. Register and deliver pass IDLE, LOOK and OUT; a dequeue adds a READ
// state for the queue RAM read, and release repeats that read per queued handle.
// Reset clears the sequencer and all entry modes; no clearing pass.
// A stalled result holds the sequencer until m_ready.
module udp_endpoint_demux_table_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  udt_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output udt_pkg::out_t m_data
);
    import udt_pkg::*;

    udt_core_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* rtl/udt_queue_ram.sv */
// Simple dual-port RAM for the handle queues, registered read.
// Generic; no package dependency.
module udt_queue_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/udt_match.sv */
// Parallel tag compare and first-hit select over all endpoint slots.
// Depends on udt_pkg.
module udt_match (
    input  udt_pkg::in_t                    req,
    input  udt_pkg::mode_t                  mode  [udt_pkg::SLOT_COUNT],
    input  udt_pkg::tag_t                   tag   [udt_pkg::SLOT_COUNT],
    input  logic [udt_pkg::CNT_W-1:0]       cnt   [udt_pkg::SLOT_COUNT],
    output udt_pkg::match_t                 hit,
    output udt_pkg::match_t                 free_slot
);
    import udt_pkg::*;

    logic [SLOT_COUNT-1:0] sel_vec;
    logic [SLOT_COUNT-1:0] free_vec;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            logic live, exact, dlv, lpm;
            live  = (mode[i] != MODE_FREE);
            exact = live && tag[i].ip == req.remote_ip
                    && tag[i].rport == req.remote_port
                    && tag[i].lport == req.local_port;
            dlv   = live && tag[i].lport == req.local_port
                    && (tag[i].rport == '0 || tag[i].rport == req.remote_port)
                    && (tag[i].ip == '0 || tag[i].ip == req.remote_ip)
                    && cnt[i] < CNT_W'(QUEUE_DEPTH);
            lpm   = live && tag[i].ip == '0 && tag[i].lport == req.local_port;
            case (req.func)
                FN_DELIVER: sel_vec[i] = dlv;
                FN_RECV_LP: sel_vec[i] = lpm;
                default:    sel_vec[i] = exact;
            endcase
            free_vec[i] = (mode[i] == MODE_FREE);
        end
    end

    always_comb begin
        hit       = '0;
        free_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (sel_vec[i]) begin
                hit.hit  = 1'b1;
                hit.slot = SLOT_W'(i);
            end
            if (free_vec[i]) begin
                free_slot.hit  = 1'b1;
                free_slot.slot = SLOT_W'(i);
            end
        end
    end

endmodule

/* rtl/udt_core_ctrl.sv */
// Sequencer and entry state: tags, modes, queue pointers; drives the queue RAM.
// Depends on udt_pkg, udt_match and udt_queue_ram.
module udt_core_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  udt_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output udt_pkg::out_t   m_data
);
    import udt_pkg::*;

    state_t state_reg, state_next;
    in_t    in_reg;
    out_t   out_reg, out_next;
    logic [SLOT_W-1:0] sel_reg, sel_next;
    logic   more_reg, more_next;

    mode_t             mode_reg [SLOT_COUNT];
    tag_t              tag_reg  [SLOT_COUNT];
    logic [CNT_W-1:0]  cnt_reg  [SLOT_COUNT];
    logic [HEAD_W-1:0] head_reg [SLOT_COUNT];
    logic [HEAD_W-1:0] tail_reg [SLOT_COUNT];

    match_t hit, free_slot;

    logic              tag_we, mode_we, ptr_we;
    logic [SLOT_W-1:0] wr_slot;
    mode_t             mode_wd;
    logic [CNT_W-1:0]  cnt_wd;
    logic [HEAD_W-1:0] head_wd, tail_wd;

    logic                   ram_we, ram_re;
    logic [QADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [HANDLE_BITS-1:0] ram_rdata;

    udt_match u_match (
        .req       (in_reg),
        .mode      (mode_reg),
        .tag       (tag_reg),
        .cnt       (cnt_reg),
        .hit       (hit),
        .free_slot (free_slot)
    );

    udt_queue_ram #(
        .DEPTH (QWORDS),
        .WIDTH (HANDLE_BITS),
        .AW    (QADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (HANDLE_BITS'(in_reg.buffer_handle)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                case (in_reg.func)
                    FN_REGISTER, FN_DELIVER: state_next = S_OUT;
                    FN_RELEASE, FN_RECV, FN_RECV_LP: begin
                        if (hit.hit && cnt_reg[hit.slot] != '0) begin
                            state_next = S_READ;
                        end else begin
                            state_next = S_OUT;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_READ: state_next = S_OUT;
            S_OUT: begin
                if (m_ready) begin
                    state_next = more_reg ? S_READ : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and entry updates
    always_comb begin
        out_next  = out_reg;
        sel_next  = sel_reg;
        more_next = more_reg;
        tag_we    = 1'b0;
        mode_we   = 1'b0;
        ptr_we    = 1'b0;
        wr_slot   = hit.slot;
        mode_wd   = MODE_USED;
        cnt_wd    = cnt_reg[hit.slot];
        head_wd   = head_reg[hit.slot];
        tail_wd   = tail_reg[hit.slot];
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = q_addr(hit.slot, tail_reg[hit.slot]);
        ram_raddr = q_addr(hit.slot, head_reg[hit.slot]);
        unique case (state_reg)
            S_LOOK: begin
                out_next  = '{ST_OK, 3'(hit.slot), 16'd0, 1'b0, 1'b0, 1'b1};
                more_next = 1'b0;
                sel_next  = hit.slot;
                case (in_reg.func)
                    FN_REGISTER: begin
                        if (hit.hit) begin
                            out_next.status = ST_DUP;
                        end else if (free_slot.hit) begin
                            wr_slot       = free_slot.slot;
                            tag_we        = 1'b1;
                            mode_we       = 1'b1;
                            mode_wd       = MODE_USED;
                            ptr_we        = 1'b1;
                            cnt_wd        = '0;
                            head_wd       = '0;
                            tail_wd       = '0;
                            out_next.slot = 3'(free_slot.slot);
                        end else begin
                            out_next.status = ST_FULL;
                            out_next.slot   = 3'd0;
                        end
                    end
                    FN_RELEASE: begin
                        if (!hit.hit) begin
                            out_next.status = ST_NOMATCH;
                            out_next.slot   = 3'd0;
                        end else begin
                            mode_we = 1'b1;
                            mode_wd = MODE_FREE;
                            ram_re  = (cnt_reg[hit.slot] != '0);
                        end
                    end
                    FN_DELIVER: begin
                        if (!hit.hit) begin
                            out_next.status = ST_DROPPED;
                            out_next.slot   = 3'd0;
                        end else begin
                            ram_we  = 1'b1;
                            ptr_we  = 1'b1;
                            cnt_wd  = cnt_reg[hit.slot] + 1'b1;
                            tail_wd = ptr_inc(tail_reg[hit.slot]);
                            if (mode_reg[hit.slot] == MODE_WAIT) begin
                                mode_we       = 1'b1;
                                mode_wd       = MODE_USED;
                                out_next.wake = 1'b1;
                            end
                        end
                    end
                    FN_RECV, FN_RECV_LP: begin
                        if (!hit.hit) begin
                            out_next.status = ST_NOMATCH;
                            out_next.slot   = 3'd0;
                        end else if (cnt_reg[hit.slot] == '0) begin
                            mode_we         = 1'b1;
                            mode_wd         = MODE_WAIT;
                            out_next.status = ST_WAITING;
                        end else begin
                            ram_re = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_READ: begin
                wr_slot   = sel_reg;
                ptr_we    = 1'b1;
                cnt_wd    = cnt_reg[sel_reg] - 1'b1;
                head_wd   = ptr_inc(head_reg[sel_reg]);
                tail_wd   = tail_reg[sel_reg];
                out_next  = '{ST_OK, 3'(sel_reg), 16'(ram_rdata), 1'b1, 1'b0, 1'b1};
                more_next = 1'b0;
                if (in_reg.func == FN_RELEASE) begin
                    out_next.last = (cnt_reg[sel_reg] == CNT_W'(1));
                    more_next     = (cnt_reg[sel_reg] != CNT_W'(1));
                end
            end
            S_OUT: begin
                ram_raddr = q_addr(sel_reg, head_reg[sel_reg]);
                ram_re    = m_ready && more_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            more_reg  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                mode_reg[i] <= MODE_FREE;
            end
        end else begin
            state_reg <= state_next;
            more_reg  <= more_next;
            if (mode_we) begin
                mode_reg[wr_slot] <= mode_wd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        out_reg <= out_next;
        sel_reg <= sel_next;
        if (tag_we) begin
            tag_reg[wr_slot] <= '{in_reg.remote_ip, in_reg.remote_port, in_reg.local_port};
        end
        if (ptr_we) begin
            cnt_reg[wr_slot]  <= cnt_wd;
            head_reg[wr_slot] <= head_wd;
            tail_reg[wr_slot] <= tail_wd;
        end
    end

endmodule
